// File: design/load_store_queue_macros.svh
// assertion helpers shared by the queue modules
`ifndef LOAD_STORE_QUEUE_MACROS_SVH
`define LOAD_STORE_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LSQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lsq_pkg.sv
package lsq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = 2;
    localparam int ID_W   = 32;
    localparam int ADDR_W = 64;
    localparam int OCC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic match;
        logic push;
        logic pop;
        logic commit;
        logic load_out;
    } t_lsq_ctl;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             head_rdy;
    } t_lsq_stat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    // physical slot of a queue offset counted from the head
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (PTR_W + 1)'(DEPTH)) begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // queue offset of a physical slot
    function automatic logic [PTR_W-1:0] offset_of(input logic [PTR_W-1:0] slot,
                                                   input logic [PTR_W-1:0] head);
        logic [PTR_W:0] dif;
        if (slot >= head) begin
            dif = {1'b0, slot} - {1'b0, head};
        end else begin
            dif = {1'b0, slot} + (PTR_W + 1)'(DEPTH) - {1'b0, head};
        end
        return dif[PTR_W-1:0];
    endfunction

endpackage

// File: design/lsq_ifs.sv
interface lsq_req_if;
    import lsq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   req_id;
    logic              is_store;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output command, output req_id, output is_store,
                    output address, input ready);
    modport sink   (input valid, input command, input req_id, input is_store,
                    input address, output ready);
endinterface

interface lsq_rsp_if;
    import lsq_pkg::*;

    logic             valid;
    logic             ready;
    logic             accepted;
    logic             store_found;
    logic             store_ready;
    logic [OCC_W-1:0] occupancy;
    logic             full_res;
    logic             empty_res;

    modport source (output valid, output accepted, output store_found,
                    output store_ready, output occupancy, output full_res,
                    output empty_res, input ready);
    modport sink   (input valid, input accepted, input store_found,
                    input store_ready, input occupancy, input full_res,
                    input empty_res, output ready);
endinterface

// File: design/lsq_ctrl.sv
`include "load_store_queue_macros.svh"

module lsq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lsq_pkg::t_lsq_stat i_stat,
    output lsq_pkg::t_lsq_ctl  o_ctl
);
    import lsq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_ctl.match = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    o_ctl.load_out = 1'b1;
                    o_ctl.push     = (i_stat.cmd == CMD_ALLOC) && !i_stat.full;
                    o_ctl.pop      = (i_stat.cmd == CMD_RETIRE) && !i_stat.empty
                                     && i_stat.head_rdy;
                    o_ctl.commit   = (i_stat.cmd == CMD_COMMIT);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `LSQ_ASSERT_IMPL(a_push_pop_excl, i_clk, i_rst_n, o_ctl.push, !o_ctl.pop, "push and pop together")
    `LSQ_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_ctl.push, !i_stat.full, "push into a full queue")
    `LSQ_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, o_ctl.load_out, r_out_valid, "result not presented")
    `LSQ_ASSERT_NEXT(a_accept_match, i_clk, i_rst_n, o_ctl.load_in, r_state == S_MATCH, "accept without match step")

endmodule

// File: design/lsq_dp.sv
`include "load_store_queue_macros.svh"

module lsq_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lsq_pkg::t_lsq_ctl         i_ctl,
    output lsq_pkg::t_lsq_stat        o_stat,
    input  logic [lsq_pkg::CMD_W-1:0]  i_command,
    input  logic [lsq_pkg::ID_W-1:0]   i_req_id,
    input  logic                      i_is_store,
    input  logic [lsq_pkg::ADDR_W-1:0] i_address,
    output logic                      o_accepted,
    output logic                      o_store_found,
    output logic                      o_store_ready,
    output logic [lsq_pkg::OCC_W-1:0]  o_occupancy,
    output logic                      o_full_res,
    output logic                      o_empty_res
);
    import lsq_pkg::*;

    // captured command beat
    logic [CMD_W-1:0]  r_cmd;
    logic [ID_W-1:0]   r_id;
    logic              r_store;
    logic [ADDR_W-1:0] r_addr;

    // queue entries
    logic [ID_W-1:0]   r_slot_id   [DEPTH];
    logic              r_slot_store[DEPTH];
    logic [ADDR_W-1:0] r_slot_addr [DEPTH];
    logic [DEPTH-1:0]  r_slot_rdy;

    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // match vectors: id hits by slot, store hits and ready marks by offset
    logic [DEPTH-1:0]  r_id_hit;
    logic [DEPTH-1:0]  r_st_off;
    logic [DEPTH-1:0]  r_rdy_off;
    logic [DEPTH-1:0]  n_id_hit;
    logic [DEPTH-1:0]  n_st_off;
    logic [DEPTH-1:0]  n_rdy_off;
    logic [DEPTH-1:0]  st_slot;
    logic [DEPTH-1:0]  youngest;

    logic              q_found;
    logic              q_ready;

    always_comb begin
        logic [PTR_W-1:0] sl;
        for (int s = 0; s < DEPTH; s++) begin
            n_id_hit[s] = (CNT_W'(offset_of(PTR_W'(s), r_head)) < r_count)
                          && (r_slot_id[s] == r_id);
            st_slot[s]  = r_slot_store[s] && (r_slot_addr[s] == r_addr);
        end
        for (int i = 0; i < DEPTH; i++) begin
            sl           = slot_of(r_head, PTR_W'(i));
            n_st_off[i]  = (CNT_W'(i) < r_count) && st_slot[sl];
            n_rdy_off[i] = r_slot_rdy[sl];
        end
    end

    // youngest live store hit: no hit at a larger offset
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            youngest[i] = r_st_off[i] && (((r_st_off >> i) >> 1) == '0);
        end
    end

    assign q_found = (r_cmd == CMD_QUERY) && (r_st_off != '0);
    assign q_ready = (r_cmd == CMD_QUERY) && ((youngest & r_rdy_off) != '0);

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.full     = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.head_rdy = r_slot_rdy[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_ctl.push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (i_ctl.pop) begin
                r_head <= ptr_inc(r_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd   <= i_command;
            r_id    <= i_req_id;
            r_store <= i_is_store;
            r_addr  <= i_address;
        end
        if (i_ctl.match) begin
            r_id_hit  <= n_id_hit;
            r_st_off  <= n_st_off;
            r_rdy_off <= n_rdy_off;
        end
        if (i_ctl.push) begin
            r_slot_id[r_tail]    <= r_id;
            r_slot_store[r_tail] <= r_store;
            r_slot_addr[r_tail]  <= r_addr;
            r_slot_rdy[r_tail]   <= 1'b0;
        end
        if (i_ctl.commit) begin
            r_slot_rdy <= r_slot_rdy | r_id_hit;
        end
        if (i_ctl.load_out) begin
            o_accepted    <= i_ctl.push || i_ctl.pop;
            o_store_found <= q_found;
            o_store_ready <= q_ready;
            o_occupancy   <= OCC_W'(n_count);
            o_full_res    <= (n_count == CNT_W'(DEPTH));
            o_empty_res   <= (n_count == '0);
        end
    end

    `LSQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "count beyond depth")
    `LSQ_ASSERT_IMPL(a_ptr_gap, i_clk, i_rst_n, !o_stat.full && !o_stat.empty, r_head != r_tail, "pointers meet while partly filled")

endmodule

// File: design/load_store_queue.sv
// in-order load/store queue of DEPTH entries (lsq_pkg::DEPTH)
// i_req carries one command beat: allocate, retire head, commit by id or
// query stores by address; o_rsp returns exactly one result beat per command
// with accepted, store_found, store_ready and the occupancy after the command
// the sequencer takes one command at a time, so a new command is taken only
// once the last one has passed its update step and its result is in the
// result register
// the three steps are capture, a parallel id/address compare over all slots
// into registered hit vectors, then the queue update and result register
// the result register parts the two sides: the next command is taken while
// an earlier result still waits; if the receiver stalls, the update step
// holds until the result register frees, and i_req.ready stays low meanwhile
// reset (synchronous, active low) empties the queue: head, tail and count go
// to zero; entry contents are not cleared since only queued entries are read
module load_store_queue (
    input logic        i_clk,
    input logic        i_rst_n,
    lsq_req_if.sink    i_req,
    lsq_rsp_if.source  o_rsp
);
    import lsq_pkg::*;

    t_lsq_ctl  ctl;
    t_lsq_stat stat;

    // sequencer: handshakes and the update decision
    lsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    // entries, pointers, compare vectors and result register
    lsq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .i_command     (i_req.command),
        .i_req_id      (i_req.req_id),
        .i_is_store    (i_req.is_store),
        .i_address     (i_req.address),
        .o_accepted    (o_rsp.accepted),
        .o_store_found (o_rsp.store_found),
        .o_store_ready (o_rsp.store_ready),
        .o_occupancy   (o_rsp.occupancy),
        .o_full_res    (o_rsp.full_res),
        .o_empty_res   (o_rsp.empty_res)
    );

endmodule
